/* src/rwc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rwc_pkg;
    localparam int KERNEL_WIDTH_DEF  = 3;
    localparam int KERNEL_HEIGHT_DEF = 3;
    localparam int COEF_W   = 16;
    localparam int COL_W    = 48;
    localparam int PIX_W    = 24;
    localparam int CH_W     = 8;
    // 9 products of 8x16 bits: 24-bit product, 4 bits of headroom
    localparam int ACC_W    = 28;
    localparam int SUM_W    = 20;
    localparam int QUO_W    = 9;
    localparam logic [SUM_W-1:0] Q_ONE = 20'd256;
    localparam logic [COL_W-1:0] COL0_RST = 48'h0;
    localparam logic [COL_W-1:0] COL1_RST = 48'h000001000000;
    localparam logic [COL_W-1:0] COL2_RST = 48'h0;
    localparam logic [1:0] REG_COL0 = 2'd0;
    localparam logic [1:0] REG_COL1 = 2'd1;
    localparam logic [1:0] REG_COL2 = 2'd2;
    localparam int LAT = QUO_W + 2;
endpackage
`default_nettype wire

/* src/rgb_window_convolution.sv */
`timescale 1ns / 1ps
`default_nettype none
// Normalised 3x3 RGB convolution. One window enters per clock and one filtered
// pixel leaves per clock; each of the three channel lanes holds a nine-step
// pipelined divider. The pipeline advances whenever the output is free or
// taken, so backpressure stalls it as a whole.
// Coefficients are signed Q8.8; their sum (zero replaced by 1.0) is the divisor.
module rgb_window_convolution
    import rwc_pkg::*;
#(
    parameter int KERNEL_WIDTH  = KERNEL_WIDTH_DEF,
    parameter int KERNEL_HEIGHT = KERNEL_HEIGHT_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [COL_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    // pixel_c0_r0, c0_r1, c0_r2, c1_r0 .. c2_r2, 24 bits each
    input  wire logic [9*PIX_W-1:0] s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    // red_out, green_out, blue_out
    output logic [3*CH_W-1:0]     m_axis_tdata
);
    logic [COL_W-1:0] r_col [3];
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [LAT:0] r_vld;
    logic en;

    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = r_vld[LAT];

    // coefficient registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col[0] <= COL0_RST; r_col[1] <= COL1_RST; r_col[2] <= COL2_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COL0: r_col[0] <= i_cfg_data;
                REG_COL1: r_col[1] <= i_cfg_data;
                REG_COL2: r_col[2] <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // derived coefficient sum
    always_comb begin
        n_sum = '0;
        for (int x = 0; x < 3; x++)
            for (int y = 0; y < 3; y++)
                if (x < KERNEL_WIDTH && y < KERNEL_HEIGHT)
                    n_sum = n_sum + SUM_W'($signed(r_col[x][16*y +: 16]));
        if (n_sum == '0) n_sum = Q_ONE;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_sum <= Q_ONE;
        else r_sum <= n_sum;
    end

    // valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-1:0], s_axis_tvalid};
    end

    logic [9*COEF_W-1:0] coefs;
    assign coefs = {r_col[2], r_col[1], r_col[0]};

    genvar c, k;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            logic [9*CH_W-1:0] px;
            for (k = 0; k < 9; k++) begin : g_px
                assign px[k*CH_W +: CH_W] = s_axis_tdata[k*PIX_W + (2-c)*CH_W +: CH_W];
            end
            rwc_lane #(.KW(KERNEL_WIDTH), .KH(KERNEL_HEIGHT)) u_lane (
                .i_clk(i_clk), .i_en(en), .i_px(px), .i_coef(coefs),
                .i_div(r_sum), .o_ch(m_axis_tdata[c*CH_W +: CH_W]));
        end
    endgenerate

    // checks
    a_zero_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum != '0) else $error("zero divisor");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output lost");
endmodule
`default_nettype wire

/* src/rwc_lane.sv */
`timescale 1ns / 1ps
`default_nettype none
// one colour channel: multiply-accumulate, then restoring division over stages
module rwc_lane
    import rwc_pkg::*;
#(
    parameter int KW = KERNEL_WIDTH_DEF,
    parameter int KH = KERNEL_HEIGHT_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic [9*CH_W-1:0]       i_px,
    input  wire logic [9*COEF_W-1:0]     i_coef,
    input  wire logic signed [SUM_W-1:0] i_div,
    output logic [CH_W-1:0]              o_ch
);
    // stage 0: products
    logic signed [ACC_W-1:0] r_prod [9];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 9; k++) begin
                if ((k / 3) < KW && (k % 3) < KH)
                    r_prod[k] <= ACC_W'($signed({1'b0, i_px[k*CH_W +: CH_W]})
                                 * $signed(i_coef[k*COEF_W +: COEF_W]));
                else
                    r_prod[k] <= '0;
            end
        end
    end

    // stage 1: sum, sign handling; clamp detection for negative quotient
    logic signed [ACC_W-1:0] n_acc;
    always_comb begin
        n_acc = '0;
        for (int k = 0; k < 9; k++) n_acc = n_acc + r_prod[k];
    end
    logic [ACC_W-1:0]  r_num [QUO_W+1];
    logic [SUM_W-1:0]  r_den [QUO_W+1];
    logic [QUO_W-1:0]  r_q   [QUO_W+1];
    logic              r_neg [QUO_W+1];
    logic [ACC_W-1:0]  r_rem [QUO_W+1];
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= n_acc[ACC_W-1] ? ACC_W'(-n_acc) : n_acc;
            r_den[0] <= i_div[SUM_W-1] ? SUM_W'(-i_div) : i_div;
            r_neg[0] <= n_acc[ACC_W-1] ^ i_div[SUM_W-1];
            r_q[0]   <= '0;
            r_rem[0] <= '0;
        end
    end

    // restoring steps, one quotient bit each; bits above QUO_W saturate
    genvar s;
    generate
        for (s = 1; s <= QUO_W; s++) begin : g_div
            localparam int B = QUO_W - s;
            logic [ACC_W+SUM_W:0] t;
            logic ge;
            assign t  = {{(SUM_W+1){1'b0}}, r_num[s-1]};
            assign ge = (t >> B) >= {{(ACC_W+1){1'b0}}, r_den[s-1]};
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_den[s] <= r_den[s-1];
                    r_neg[s] <= r_neg[s-1];
                    if (s == 1) begin
                        // sets saturation flag when quotient >= 512
                        r_rem[s] <= ((t >> QUO_W) >= {{(ACC_W+1){1'b0}}, r_den[s-1]})
                                    ? ACC_W'(1) : '0;
                    end else begin
                        r_rem[s] <= r_rem[s-1];
                    end
                    if (ge) begin
                        r_num[s] <= ACC_W'(t - ({{(ACC_W+1){1'b0}}, r_den[s-1]} << B));
                        r_q[s]   <= r_q[s-1] | QUO_W'(1 << B);
                    end else begin
                        r_num[s] <= r_num[s-1];
                        r_q[s]   <= r_q[s-1];
                    end
                end
            end
        end
    endgenerate

    // final clamp
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QUO_W] || (r_q[QUO_W] == '0 && r_rem[QUO_W] == '0)) o_ch <= '0;
            else if (r_rem[QUO_W] != '0 || r_q[QUO_W][QUO_W-1]) o_ch <= '1;
            else o_ch <= r_q[QUO_W][CH_W-1:0];
        end
    end
    // unused tail of the delay arrays
    logic unused;
    assign unused = ^{r_num[QUO_W], r_den[QUO_W]};
endmodule
`default_nettype wire

/* tb/rgb_window_convolution_tb.sv */
`timescale 1ns / 1ps
module rgb_window_convolution_tb;
    import rwc_pkg::*;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } t_rgb;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [1:0]           i_cfg_idx = '0;
    logic [COL_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [9*PIX_W-1:0]   s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [3*CH_W-1:0]    m_axis_tdata;

    rgb_window_convolution dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor state
    logic [COL_W-1:0] kernel_cols [3];
    int               kernel_div;
    t_rgb             pixels_due [$];
    int               n_errors = 0;
    int               send_idle = 0;
    int               recv_idle = 0;

    function automatic int coef_of(int x, int y);
        logic signed [COEF_W-1:0] c;
        c = kernel_cols[x][16*y +: 16];
        return int'(c);
    endfunction

    function automatic void refresh_divisor();
        int s;
        s = 0;
        for (int x = 0; x < KERNEL_WIDTH_DEF; x++)
            for (int y = 0; y < KERNEL_HEIGHT_DEF; y++)
                s += coef_of(x, y);
        kernel_div = (s == 0) ? 256 : s;
    endfunction

    function automatic logic [CH_W-1:0] clamp_channel(longint acc);
        longint q;
        q = acc / longint'(kernel_div);
        if (q > 255) q = 255;
        else if (q < 0) q = 0;
        return q[CH_W-1:0];
    endfunction

    function automatic t_rgb filter_window(logic [9*PIX_W-1:0] win);
        longint ar, ag, ab, c;
        logic [PIX_W-1:0] p;
        t_rgb r;
        ar = 0; ag = 0; ab = 0;
        for (int x = 0; x < KERNEL_WIDTH_DEF; x++)
            for (int y = 0; y < KERNEL_HEIGHT_DEF; y++) begin
                p = win[(x*3+y)*PIX_W +: PIX_W];
                c = coef_of(x, y);
                ar += longint'(p[23:16]) * c;
                ag += longint'(p[15:8]) * c;
                ab += longint'(p[7:0]) * c;
            end
        r.red = clamp_channel(ar);
        r.green = clamp_channel(ag);
        r.blue = clamp_channel(ab);
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        n_errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_rgb got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pixels_due.size() == 0) begin
                report_mismatch("unexpected item", 0, 0);
            end else begin
                want = pixels_due.pop_front();
                if (got.red !== want.red) report_mismatch("red", got.red, want.red);
                if (got.green !== want.green)
                    report_mismatch("green", got.green, want.green);
                if (got.blue !== want.blue) report_mismatch("blue", got.blue, want.blue);
            end
        end
    end

    // receiver stall
    always @(negedge i_clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle);

    // valid stays high after an item until the next idle cycle or drain
    task automatic send_window(logic [9*PIX_W-1:0] win);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= win;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pixels_due.push_back(filter_window(win));
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pixels_due.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
    endtask

    task automatic write_column(logic [1:0] idx, logic [COL_W-1:0] val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx <= REG_COL2) kernel_cols[idx] = val;
        refresh_divisor();
    endtask

    function automatic logic [9*PIX_W-1:0] rand_window();
        logic [9*PIX_W-1:0] w;
        for (int i = 0; i < 9; i++) w[i*PIX_W +: PIX_W] = $urandom_range(24'hFFFFFF);
        return w;
    endfunction

    function automatic logic [COL_W-1:0] rand_column(int span);
        logic [COL_W-1:0] v;
        logic signed [COEF_W-1:0] c;
        for (int y = 0; y < 3; y++) begin
            c = (span == 0) ? COEF_W'($urandom) : COEF_W'($urandom_range(2*span) - span);
            v[16*y +: 16] = c;
        end
        return v;
    endfunction

    // directed: extremes with the identity kernel
    task automatic test_identity_extremes();
        send_window('0);
        send_window({9{24'hFFFFFF}});
        send_window({{4{24'h000000}}, 24'hFFFFFF, {4{24'h000000}}});
        send_window({{4{24'hFFFFFF}}, 24'h123456, {4{24'hFFFFFF}}});
        send_window(rand_window());
    endtask

    // directed: box blur, zero-sum edge kernel, negative and huge coefficients
    task automatic test_kernel_cases();
        write_column(REG_COL0, {3{16'h0100}});
        write_column(REG_COL1, {3{16'h0100}});
        write_column(REG_COL2, {3{16'h0100}});
        send_window({9{24'hFFFFFF}});
        send_window(rand_window());
        // zero coefficient sum falls back to 1.0
        write_column(REG_COL0, {3{16'hFF00}});
        write_column(REG_COL2, {3{16'h0000}});
        send_window({{3{24'hFFFFFF}}, {6{24'h0}}});
        send_window({{6{24'hFFFFFF}}, {3{24'h0}}});
        send_window(rand_window());
        // extreme coefficients, negative result clamps to zero
        write_column(REG_COL0, {3{16'h8000}});
        write_column(REG_COL1, {3{16'h7FFF}});
        write_column(REG_COL2, {16'h8000, 16'h7FFF, 16'hFFFF});
        send_window({9{24'hFFFFFF}});
        send_window(rand_window());
        write_column(REG_COL0, {3{16'hFFFF}});
        write_column(REG_COL1, 48'hFFFFFFFFFFFF);
        write_column(REG_COL2, {16'h0001, 16'h0001, 16'h0001});
        send_window({9{24'hFFFFFF}});
        send_window(rand_window());
        // index beyond the column registers is ignored
        write_column(2'd3, 48'h123456789ABC);
        send_window(rand_window());
    endtask

    // random windows over several random kernels
    task automatic test_random_windows(int count);
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) begin
                write_column(REG_COL0, rand_column((i % 120 == 0) ? 300 : 0));
                write_column(REG_COL1, rand_column(600));
                write_column(REG_COL2, rand_column(300));
            end
            send_window(rand_window());
        end
    endtask

    initial begin
        kernel_cols[0] = COL0_RST;
        kernel_cols[1] = COL1_RST;
        kernel_cols[2] = COL2_RST;
        refresh_divisor();
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_idle = 20; recv_idle = 59;
        test_identity_extremes();
        test_kernel_cases();
        test_random_windows(160);
        send_idle = 59; recv_idle = 20;
        test_random_windows(160);
        send_idle = 0; recv_idle = 0;
        test_random_windows(160);
        drain();
        if (n_errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Verification failed");
        $finish;
    end
endmodule

/* rgb_window_convolution.f */
src/rwc_pkg.sv
src/rwc_lane.sv
src/rgb_window_convolution.sv
tb/rgb_window_convolution_tb.sv
